>>> sv/rmq_pkg.sv
`timescale 1ns / 1ps
package rmq_pkg;

  typedef logic [1:0] comp_t;

  localparam comp_t COMP_W = 2'd0;
  localparam comp_t COMP_X = 2'd1;
  localparam comp_t COMP_Y = 2'd2;
  localparam comp_t COMP_Z = 2'd3;

endpackage

>>> sv/rmq_in_if.sv
`timescale 1ns / 1ps
interface rmq_in_if #(
  parameter int VALUE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] m00;
  logic signed [VALUE_WIDTH-1:0] m01;
  logic signed [VALUE_WIDTH-1:0] m02;
  logic signed [VALUE_WIDTH-1:0] m10;
  logic signed [VALUE_WIDTH-1:0] m11;
  logic signed [VALUE_WIDTH-1:0] m12;
  logic signed [VALUE_WIDTH-1:0] m20;
  logic signed [VALUE_WIDTH-1:0] m21;
  logic signed [VALUE_WIDTH-1:0] m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

>>> sv/rmq_out_if.sv
`timescale 1ns / 1ps
interface rmq_out_if #(
  parameter int VALUE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] quat_w;
  logic signed [VALUE_WIDTH-1:0] quat_x;
  logic signed [VALUE_WIDTH-1:0] quat_y;
  logic signed [VALUE_WIDTH-1:0] quat_z;
  rmq_pkg::comp_t                largest_component;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, largest_component,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, largest_component,
                output ready);
endinterface

>>> sv/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// The pipeline has RB = (VALUE_WIDTH + FRAC_BITS + 3) / 2 square-root stages and
// NW = VALUE_WIDTH + FRAC_BITS + 2 divider stages.
// Throughput: one request per cycle; the whole pipeline holds when the output stalls.
// The root is taken one bit per stage, the three quotients one bit per stage each.
// Reset (rst_ni, asynchronous, active low) clears the stage valid bits only.
module rotation_matrix_to_quaternion #(
  parameter int VALUE_WIDTH = 16,
  parameter int FRAC_BITS   = 14
) (
  input logic       clk_i,
  input logic       rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o
);
  import rmq_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int TW    = W + 2;
  localparam int NB    = TW + F;
  localparam int RB    = (NB + 1) / 2;
  localparam int SB    = 2 * RB;
  localparam int SRW   = RB + 3;
  localparam int DW    = W + 1;
  localparam int NW    = W + F + 2;
  localparam int DENW  = RB + 3;
  localparam int REMW  = RB + 4;
  localparam int CW    = (RB > W) ? RB : W;
  localparam logic [NW-1:0] QMAX = NW'({(W-1){1'b1}});

  logic en;
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // front stage: candidates, selection, clamp, off-diagonal terms
  logic signed [W+1:0] cand [4];
  logic signed [W+1:0] big;
  comp_t               sel;
  logic signed [W+2:0] t_s;
  logic [TW-1:0]       t_c;
  logic signed [DW-1:0] dd [3];
  logic signed [DW-1:0] e01, e02, e10, e12, e20, e21;

  always_comb begin
    cand[0] = (W+2)'(in_i.m00) + (W+2)'(in_i.m11) + (W+2)'(in_i.m22);
    cand[1] = (W+2)'(in_i.m00) - (W+2)'(in_i.m11) - (W+2)'(in_i.m22);
    cand[2] = (W+2)'(in_i.m11) - (W+2)'(in_i.m00) - (W+2)'(in_i.m22);
    cand[3] = (W+2)'(in_i.m22) - (W+2)'(in_i.m00) - (W+2)'(in_i.m11);
    big = cand[0];
    sel = COMP_W;
    if (cand[1] > big) begin big = cand[1]; sel = COMP_X; end
    if (cand[2] > big) begin big = cand[2]; sel = COMP_Y; end
    if (cand[3] > big) begin big = cand[3]; sel = COMP_Z; end
    t_s = (W+3)'(big) + (W+3)'(signed'({1'b0, 1'b1, {F{1'b0}}}));
    if (t_s < (W+3)'(signed'(2'sb01))) begin
      t_c = TW'(1);
    end else begin
      t_c = t_s[TW-1:0];
    end
    e01 = DW'(in_i.m01);
    e02 = DW'(in_i.m02);
    e10 = DW'(in_i.m10);
    e12 = DW'(in_i.m12);
    e20 = DW'(in_i.m20);
    e21 = DW'(in_i.m21);
    unique case (sel)
      COMP_W: begin dd[0] = e21 - e12; dd[1] = e02 - e20; dd[2] = e10 - e01; end
      COMP_X: begin dd[0] = e21 - e12; dd[1] = e10 + e01; dd[2] = e02 + e20; end
      COMP_Y: begin dd[0] = e02 - e20; dd[1] = e10 + e01; dd[2] = e21 + e12; end
      default: begin dd[0] = e10 - e01; dd[1] = e02 + e20; dd[2] = e21 + e12; end
    endcase
  end

  // square-root pipeline, stage 0 is the front register
  logic                 sq_v_q    [RB+1];
  logic [SB-1:0]        sq_n_q    [RB+1];
  logic [SRW-1:0]       sq_rem_q  [RB+1];
  logic [RB-1:0]        sq_root_q [RB+1];
  comp_t                sq_idx_q  [RB+1];
  logic signed [DW-1:0] sq_d_q    [RB+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_n_q[0]    <= SB'({t_c, {F{1'b0}}});
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_idx_q[0]  <= sel;
      sq_d_q[0]    <= dd;
    end
  end

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    logic [SRW-1:0] rs, trial;
    logic           ge;
    always_comb begin
      rs    = {sq_rem_q[k][SRW-3:0], sq_n_q[k][SB-1:SB-2]};
      trial = {1'b0, sq_root_q[k], 2'b01};
      ge    = rs >= trial;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_n_q[k+1]    <= {sq_n_q[k][SB-3:0], 2'b00};
        sq_rem_q[k+1]  <= ge ? rs - trial : rs;
        sq_root_q[k+1] <= {sq_root_q[k][RB-2:0], ge};
        sq_idx_q[k+1]  <= sq_idx_q[k];
        sq_d_q[k+1]    <= sq_d_q[k];
      end
    end
  end

  // divider setup and pipeline
  logic [RB:0]    r1;
  logic [RB-1:0]  qb;
  logic [NW-1:0]  num0 [3];
  logic           neg0 [3];
  logic [DW-1:0]  mag0 [3];

  always_comb begin
    r1 = {1'b0, sq_root_q[RB]} + (RB+1)'(1);
    qb = r1[RB:1];
    for (int i = 0; i < 3; i++) begin
      neg0[i] = sq_d_q[RB][i][DW-1];
      mag0[i] = neg0[i] ? (~sq_d_q[RB][i] + DW'(1)) : sq_d_q[RB][i];
      num0[i] = (NW'(mag0[i]) << (F + 1)) + NW'({qb, 2'b00});
    end
  end

  logic          dv_v_q   [NW+1];
  logic [NW-1:0] dv_num_q [NW+1][3];
  logic [REMW-1:0] dv_rem_q [NW+1][3];
  logic          dv_neg_q [NW+1][3];
  logic [RB-1:0] dv_qb_q  [NW+1];
  comp_t         dv_idx_q [NW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sq_v_q[RB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_num_q[0] <= num0;
      dv_neg_q[0] <= neg0;
      for (int i = 0; i < 3; i++) dv_rem_q[0][i] <= '0;
      dv_qb_q[0]  <= qb;
      dv_idx_q[0] <= sq_idx_q[RB];
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [REMW-1:0] den;
    logic [REMW-1:0] rs [3];
    logic            ge [3];
    always_comb begin
      den = REMW'({dv_qb_q[k], 3'b000});
      for (int i = 0; i < 3; i++) begin
        rs[i] = {dv_rem_q[k][i][REMW-2:0], dv_num_q[k][i][NW-1]};
        ge[i] = rs[i] >= den;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_num_q[k+1][i] <= {dv_num_q[k][i][NW-2:0], ge[i]};
          dv_rem_q[k+1][i] <= ge[i] ? rs[i] - den : rs[i];
        end
        dv_neg_q[k+1] <= dv_neg_q[k];
        dv_qb_q[k+1]  <= dv_qb_q[k];
        dv_idx_q[k+1] <= dv_idx_q[k];
      end
    end
  end

  // saturation and output register
  logic signed [W-1:0] oth [3];
  logic signed [W-1:0] qbs;
  logic signed [W-1:0] q_d [4];
  logic                out_v_q;
  logic signed [W-1:0] q_q [4];
  comp_t               idx_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_neg_q[NW][i]) begin
        oth[i] = (dv_num_q[NW][i] > QMAX) ? signed'({1'b1, {(W-1){1'b0}}})
                                           : signed'(~dv_num_q[NW][i][W-1:0] + W'(1));
      end else begin
        oth[i] = (dv_num_q[NW][i] > QMAX) ? signed'(QMAX[W-1:0])
                                           : signed'(dv_num_q[NW][i][W-1:0]);
      end
    end
    qbs = (CW'(dv_qb_q[NW]) > CW'(QMAX[W-1:0])) ? signed'(QMAX[W-1:0])
                                               : signed'(W'(dv_qb_q[NW]));
    unique case (dv_idx_q[NW])
      COMP_W: begin q_d[0] = qbs; q_d[1] = oth[0]; q_d[2] = oth[1]; q_d[3] = oth[2]; end
      COMP_X: begin q_d[0] = oth[0]; q_d[1] = qbs; q_d[2] = oth[1]; q_d[3] = oth[2]; end
      COMP_Y: begin q_d[0] = oth[0]; q_d[1] = oth[1]; q_d[2] = qbs; q_d[3] = oth[2]; end
      default: begin q_d[0] = oth[0]; q_d[1] = oth[1]; q_d[2] = oth[2]; q_d[3] = qbs; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q   <= q_d;
      idx_q <= dv_idx_q[NW];
    end
  end

  assign out_o.valid             = out_v_q;
  assign out_o.quat_w            = q_q[0];
  assign out_o.quat_x            = q_q[1];
  assign out_o.quat_y            = q_q[2];
  assign out_o.quat_z            = q_q[3];
  assign out_o.largest_component = idx_q;

  a_sel_positive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      (out_o.largest_component == COMP_W && out_o.quat_w > 0) ||
      (out_o.largest_component == COMP_X && out_o.quat_x > 0) ||
      (out_o.largest_component == COMP_Y && out_o.quat_y > 0) ||
      (out_o.largest_component == COMP_Z && out_o.quat_z > 0))
    else $error("largest component not positive");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("request taken during output stall");

  a_front_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(sq_v_q[0]) && $stable(dv_v_q[0]))
    else $error("pipeline moved during stall");

endmodule
